[rtl/assert_macros.svh]
// Assertion macros used by weighted_discrete_sampler_unit.
// No dependencies; included by files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or temporal property, checked on every rising edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: property violated");

// Plain invariant that must hold on every rising edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("%m: invariant violated");

`endif

[rtl/wds_pkg.sv]
// Types and constants of the weighted discrete sampler.
// No dependencies; used by weighted_discrete_sampler_unit and the testbench.
package wds_pkg;

   // command codes
   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_LOAD   = 2'd1;
   localparam logic [1:0] CMD_SAMPLE = 2'd2;

   // status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_ZERO  = 2'd2;
   localparam logic [1:0] ST_FULL  = 2'd3;

   // random fraction is Q0.32
   localparam int FRAC_BITS = 32;

   // register file: one 32-bit register, word index in paddr[2]
   localparam int         CSR_ADDR_W       = 3;
   localparam int         CSR_DATA_W       = 32;
   localparam logic [0:0] REG_UNIFORM_MODE = 1'b0;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] entry_value;
      logic [15:0] entry_weight;
      logic [31:0] rand_fraction;
   } req_type;

   typedef struct packed {
      logic [31:0] sample_value;
      logic [9:0]  sample_index;
      logic [1:0]  status;
   } rsp_type;

endpackage

[rtl/wds_ram.sv]
// Simple dual-port table memory: one write port, one registered read port.
// No dependencies; instantiated by weighted_discrete_sampler_unit.
module wds_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 58
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[rtl/weighted_discrete_sampler_unit.sv]
// Weighted discrete sampler: cumulative-weight table in one synchronous RAM, inverse-CDF draw.
// Clear and load: the result goes to the result register, then the response register.
// Sample: two passes through one 32x32 multiplier, then one RAM read per search step,
// at most ceil(log2(entries)) steps (10 at 1024 entries); one beat in flight at a time.
// Reset (synchronous): empties the table, zeroes total and uniform_mode at once; no clear sweep.
// Depends on wds_pkg, wds_ram and assert_macros.svh.
`include "assert_macros.svh"

module weighted_discrete_sampler_unit #(
   parameter int TABLE_DEPTH = 1024,
   parameter int WEIGHT_BITS = 16,
   parameter int VALUE_BITS  = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  wds_pkg::req_type                    req_payload,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output wds_pkg::rsp_type                    rsp_payload,
   // register port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [wds_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [wds_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [wds_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   // ------------------------------------------------------------------
   // Derived sizes. The total never exceeds TABLE_DEPTH * (2^WEIGHT_BITS - 1),
   // which fits in WEIGHT_BITS + IDX_W bits, so it never wraps.
   // ------------------------------------------------------------------
   localparam int IDX_W  = $clog2(TABLE_DEPTH);
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int TOT_W  = WEIGHT_BITS + IDX_W;
   localparam int MEM_W  = TOT_W + VALUE_BITS;
   localparam int FRAC_W = wds_pkg::FRAC_BITS;
   localparam int PROD_W = 2 * FRAC_W;
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

   typedef enum logic [2:0] {
      S_IDLE,     // take a request beat
      S_MUL_LO,   // fraction times low word of the total
      S_MUL_HI,   // fraction times high word of the total
      S_SCALE,    // add partial products to get u, issue first probe
      S_SEARCH,   // one binary-search step per cycle
      S_FETCH,    // read data of the chosen entry is back
      S_DONE      // hand the result to the response register
   } state_type;

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [TOT_W-1:0]   total_ff, total_in;
   logic               uniform_ff, uniform_in;
   logic               rsp_valid_ff, rsp_valid_in;
   wds_pkg::rsp_type   rsp_ff, rsp_in;
   wds_pkg::rsp_type   res_ff, res_in;
   logic [FRAC_W-1:0]  frac_ff, frac_in;
   logic [PROD_W-1:0]  prod_lo_ff, prod_lo_in;
   logic [PROD_W-1:0]  prod_hi_ff, prod_hi_in;
   logic [TOT_W-1:0]   u_ff, u_in;
   logic [IDX_W-1:0]   lo_ff, lo_in;
   logic [IDX_W-1:0]   hi_ff, hi_in;
   logic [IDX_W-1:0]   mid_ff, mid_in;

   // ------------------------------------------------------------------
   // Table RAM: each word holds {cumulative weight, value}
   // ------------------------------------------------------------------
   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr;
   logic [MEM_W-1:0]   mem_wdata;
   logic               mem_re;
   logic [IDX_W-1:0]   mem_raddr;
   logic [MEM_W-1:0]   mem_rdata;
   logic [TOT_W-1:0]   rd_cum;
   logic [VALUE_BITS-1:0] rd_val;

   wds_ram #(
      .DEPTH (TABLE_DEPTH),
      .WIDTH (MEM_W)
   ) u_table (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   assign rd_cum = mem_rdata[MEM_W-1:VALUE_BITS];
   assign rd_val = mem_rdata[VALUE_BITS-1:0];

   // ------------------------------------------------------------------
   // Handshakes and register port
   // ------------------------------------------------------------------
   logic accept;
   logic out_free;
   logic cfg_we;

   // Only one item is in flight; a finished result may still wait in the
   // response register while the next beat is taken.
   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign csr_pready = 1'b1;
   assign cfg_we     = csr_psel && csr_penable && csr_pwrite
                       && (csr_paddr[2] == wds_pkg::REG_UNIFORM_MODE);
   assign csr_prdata = (csr_paddr[2] == wds_pkg::REG_UNIFORM_MODE)
                       ? wds_pkg::CSR_DATA_W'(uniform_ff) : '0;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // ------------------------------------------------------------------
   // Load datapath: weight forced to one in uniform mode, then accumulate
   // ------------------------------------------------------------------
   logic [TOT_W-1:0] load_weight;
   logic [TOT_W-1:0] total_sum;

   assign load_weight = uniform_ff ? TOT_W'(1)
                        : TOT_W'(WEIGHT_BITS'(req_payload.entry_weight));
   assign total_sum   = total_ff + load_weight;

   // ------------------------------------------------------------------
   // Scaling: u = floor(frac * total / 2^32), done as two 32x32 products
   // on one shared multiplier (low word first, then high word).
   // ------------------------------------------------------------------
   logic [PROD_W-1:0] tot_ext;
   logic [FRAC_W-1:0] mul_b;
   logic [PROD_W-1:0] mul_out;
   logic [PROD_W-1:0] scaled;

   assign tot_ext = PROD_W'(total_ff);
   assign mul_b   = (state_ff == S_MUL_LO) ? tot_ext[FRAC_W-1:0]
                                           : tot_ext[PROD_W-1:FRAC_W];
   assign mul_out = PROD_W'(frac_ff) * PROD_W'(mul_b);
   assign scaled  = prod_hi_ff + (prod_lo_ff >> FRAC_W);

   // ------------------------------------------------------------------
   // Search step: narrow [lo, hi] on the probe that just came back.
   // The answer is the first entry whose cumulative weight exceeds u.
   // ------------------------------------------------------------------
   logic [IDX_W-1:0] lo_next;
   logic [IDX_W-1:0] hi_next;
   logic [IDX_W:0]   mid_sum;

   always_comb begin
      if (rd_cum > u_ff) begin
         lo_next = lo_ff;
         hi_next = mid_ff;
      end else begin
         lo_next = mid_ff + IDX_W'(1);
         hi_next = hi_ff;
      end
      mid_sum = {1'b0, lo_next} + {1'b0, hi_next};
   end

   // ------------------------------------------------------------------
   // Control. The RAM is written only at the accept edge of a load and read
   // only while a sample is in flight, so accesses never overlap and no
   // forwarding path is needed.
   // ------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      total_in     = total_ff;
      uniform_in   = uniform_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      res_in       = res_ff;
      frac_in      = frac_ff;
      prod_lo_in   = prod_lo_ff;
      prod_hi_in   = prod_hi_ff;
      u_in         = u_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      mem_we       = 1'b0;
      mem_waddr    = IDX_W'(count_ff);
      mem_wdata    = {total_sum, VALUE_BITS'(req_payload.entry_value)};
      mem_re       = 1'b0;
      mem_raddr    = mid_ff;

      if (cfg_we) begin
         uniform_in = csr_pwdata[0];
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_in        = '0;
               res_in.status = wds_pkg::ST_OK;
               state_in      = S_DONE;
               case (req_payload.cmd)
                  wds_pkg::CMD_CLEAR: begin
                     count_in = '0;
                     total_in = '0;
                  end
                  wds_pkg::CMD_LOAD: begin
                     if (count_ff >= DEPTH_CNT) begin
                        res_in.status = wds_pkg::ST_FULL;
                     end else begin
                        // append at the fill position
                        mem_we   = 1'b1;
                        total_in = total_sum;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  wds_pkg::CMD_SAMPLE: begin
                     if (count_ff == '0) begin
                        res_in.status = wds_pkg::ST_EMPTY;
                     end else if (total_ff == '0) begin
                        res_in.status = wds_pkg::ST_ZERO;
                     end else begin
                        frac_in  = req_payload.rand_fraction;
                        state_in = S_MUL_LO;
                     end
                  end
                  default: begin
                     // unused command: no state change, plain OK result
                  end
               endcase
            end
         end

         S_MUL_LO: begin
            prod_lo_in = mul_out;
            state_in   = S_MUL_HI;
         end

         S_MUL_HI: begin
            prod_hi_in = mul_out;
            state_in   = S_SCALE;
         end

         S_SCALE: begin
            // u < total always, so the last entry bounds the search
            u_in  = TOT_W'(scaled);
            lo_in = '0;
            hi_in = IDX_W'(count_ff - CNT_W'(1));
            if (count_ff == CNT_W'(1)) begin
               // single entry: fetch it straight away
               mem_re    = 1'b1;
               mem_raddr = '0;
               state_in  = S_FETCH;
            end else begin
               mid_in    = hi_in >> 1;
               mem_re    = 1'b1;
               mem_raddr = mid_in;
               state_in  = S_SEARCH;
            end
         end

         S_SEARCH: begin
            lo_in = lo_next;
            hi_in = hi_next;
            if (lo_next < hi_next) begin
               // next probe
               mid_in    = mid_sum[IDX_W:1];
               mem_re    = 1'b1;
               mem_raddr = mid_in;
            end else begin
               // window closed: read the chosen entry's value
               mem_re    = 1'b1;
               mem_raddr = lo_next;
               state_in  = S_FETCH;
            end
         end

         S_FETCH: begin
            res_in.sample_value = 32'(rd_val);
            res_in.sample_index = 10'(lo_ff);
            res_in.status       = wds_pkg::ST_OK;
            state_in            = S_DONE;
         end

         S_DONE: begin
            // hold the result until the response register drains
            if (out_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         total_ff     <= '0;
         uniform_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         uniform_ff   <= uniform_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff     <= rsp_in;
      res_ff     <= res_in;
      frac_ff    <= frac_in;
      prod_lo_ff <= prod_lo_in;
      prod_hi_ff <= prod_hi_in;
      u_ff       <= u_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      mid_ff     <= mid_in;
   end

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= DEPTH_CNT)
   `ASSERT_ALWAYS(a_no_write_busy, clock, reset, !(mem_we && (state_ff != S_IDLE)))
   `ASSERT_IMPLIES(a_probe_in_window, clock, reset,
      (state_ff == S_SEARCH) |-> ((mid_ff >= lo_ff) && (mid_ff < hi_ff)))
   `ASSERT_IMPLIES(a_u_below_total, clock, reset,
      (state_ff == S_SEARCH) |-> (u_ff < total_ff))
   `ASSERT_IMPLIES(a_pick_in_table, clock, reset,
      (state_ff == S_FETCH) |-> (CNT_W'(lo_ff) < count_ff))

endmodule

[tb/testbench.sv]
// Self-checking testbench for weighted_discrete_sampler_unit: clear, load and draw beats
// checked against an in-bench inverse-CDF table model, under random stalls and uniform mode.
// Depends on wds_pkg and the sampler RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH        = 1024;
   localparam int WEIGHT_W     = 16;
   localparam int VALUE_W      = 32;
   localparam int MAX_REPORTED = 10;
   localparam logic [wds_pkg::CSR_ADDR_W-1:0] UNIFORM_ADDR = {wds_pkg::REG_UNIFORM_MODE, 2'b00};
   // the one command code the block ignores
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // weight patterns for generated table contents
   typedef enum int {WT_ANY, WT_TINY, WT_NONE, WT_SPARSE, WT_EDGE} weight_mix_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic             req_valid   = 1'b0;
   logic             req_ready;
   wds_pkg::req_type req_payload = '0;
   logic             rsp_valid;
   logic             rsp_ready   = 1'b0;
   wds_pkg::rsp_type rsp_payload;

   logic                           csr_psel    = 1'b0;
   logic                           csr_penable = 1'b0;
   logic                           csr_pwrite  = 1'b0;
   logic [wds_pkg::CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [wds_pkg::CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [wds_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   // pacing: calm stretches turn off random idling; hold_rsp is the long receiver hold-off
   logic calm     = 1'b0;
   logic hold_rsp = 1'b0;

   // beats waiting to be offered and results predicted for accepted beats
   wds_pkg::req_type outgoing_cmds[$];
   wds_pkg::rsp_type predicted_draws[$];

   // model of the sampler: value words, running cumulative weights, fill level, total
   logic [VALUE_W-1:0] stored_value[DEPTH];
   logic [25:0]        running_weight[DEPTH];
   int                 loaded          = 0;
   logic [25:0]        weight_sum      = '0;
   bit                 uniform_weights = 1'b0;
   int                 deepest         = 0;

   int n_accepted = 0;
   int n_results  = 0;
   int n_mismatch = 0;
   int n_clear = 0, n_load = 0, n_full = 0, n_unused = 0;
   int n_draw_ok = 0, n_draw_empty = 0, n_draw_zero = 0;
   int gap_left   = 0;
   int stall_left = 0;
   wds_pkg::rsp_type next_result;

   weighted_discrete_sampler_unit #(
      .TABLE_DEPTH (DEPTH),
      .WEIGHT_BITS (WEIGHT_W),
      .VALUE_BITS  (VALUE_W)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Apply one accepted beat to the model and return the result it must produce.
   // A draw scales the Q0.32 fraction by the total to an integer u and picks the
   // first entry whose cumulative weight is strictly above u, so zero-weight
   // entries can never win.
   function automatic wds_pkg::rsp_type apply_command(wds_pkg::req_type beat);
      wds_pkg::rsp_type res;
      logic [25:0]      w;
      logic [63:0]      scaled;
      logic [25:0]      u;
      int               lo;
      int               hi;
      int               mid;
      res = '0;
      res.status = wds_pkg::ST_OK;
      case (beat.cmd)
         wds_pkg::CMD_CLEAR: begin
            loaded     = 0;
            weight_sum = '0;
         end
         wds_pkg::CMD_LOAD: begin
            if (loaded >= DEPTH) begin
               res.status = wds_pkg::ST_FULL;
            end else begin
               w = uniform_weights ? 26'd1 : 26'(beat.entry_weight);
               weight_sum = weight_sum + w;
               stored_value[loaded]   = beat.entry_value;
               running_weight[loaded] = weight_sum;
               loaded++;
               if (loaded > deepest) deepest = loaded;
            end
         end
         wds_pkg::CMD_SAMPLE: begin
            if (loaded == 0) begin
               res.status = wds_pkg::ST_EMPTY;
            end else if (weight_sum == 0) begin
               res.status = wds_pkg::ST_ZERO;
            end else begin
               scaled = 64'(beat.rand_fraction) * 64'(weight_sum);
               u  = scaled[57:32];
               lo = 0;
               hi = loaded - 1;
               while (lo < hi) begin
                  mid = lo + ((hi - lo) >> 1);
                  if (running_weight[mid] > u) hi = mid;
                  else lo = mid + 1;
               end
               res.sample_value = stored_value[lo];
               res.sample_index = 10'(lo);
            end
         end
         default: ;  // unused command: no state change
      endcase
      return res;
   endfunction

   function automatic void flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
      n_mismatch++;
      if (n_mismatch <= MAX_REPORTED)
         $display("result %0d: %s expected %h got %h", n_results, what, want, got);
   endfunction

   // ---------------------------------------------------------------- driver
   // Predict at the edge that accepts a beat, then either hold the current beat,
   // idle for the drawn gap, or present the next pending beat.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && req_ready) begin
            next_result = apply_command(req_payload);
            predicted_draws.push_back(next_result);
            n_accepted++;
            case (req_payload.cmd)
               wds_pkg::CMD_CLEAR: n_clear++;
               wds_pkg::CMD_LOAD: begin
                  if (next_result.status == wds_pkg::ST_FULL) n_full++;
                  else n_load++;
               end
               wds_pkg::CMD_SAMPLE: begin
                  if (next_result.status == wds_pkg::ST_EMPTY) n_draw_empty++;
                  else if (next_result.status == wds_pkg::ST_ZERO) n_draw_zero++;
                  else n_draw_ok++;
               end
               default: n_unused++;
            endcase
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (outgoing_cmds.size() != 0) begin
               req_payload <= outgoing_cmds.pop_front();
               req_valid   <= 1'b1;
               gap_left = calm ? 0 : $urandom_range(0, 3);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor
   // Compare each accepted result beat with the oldest prediction, field by field,
   // then stall for the drawn number of cycles before taking the next one.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            n_results++;
            if (predicted_draws.size() == 0) begin
               flag_mismatch("unrequested result, status", '0, 32'(rsp_payload.status));
            end else begin
               next_result = predicted_draws.pop_front();
               if (rsp_payload.status !== next_result.status)
                  flag_mismatch("status", 32'(next_result.status), 32'(rsp_payload.status));
               if (rsp_payload.sample_index !== next_result.sample_index)
                  flag_mismatch("sample_index", 32'(next_result.sample_index),
                                32'(rsp_payload.sample_index));
               if (rsp_payload.sample_value !== next_result.sample_value)
                  flag_mismatch("sample_value", next_result.sample_value,
                                rsp_payload.sample_value);
            end
            stall_left = calm ? 0 : $urandom_range(0, 3);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= !hold_rsp;
         end
      end
   end

   // Alternate between randomly idling stretches and calm stretches.
   always begin
      repeat ($urandom_range(100, 400)) @(posedge clock);
      calm <= ~calm;
   end

   // Hold off the receiver for long stretches while loads keep arriving, so the
   // block backs up and drops req_ready.
   initial begin
      wait (n_accepted >= 300);
      @(posedge clock) hold_rsp <= 1'b1;
      repeat (300) @(posedge clock);
      hold_rsp <= 1'b0;
      wait (n_accepted >= 1100);
      @(posedge clock) hold_rsp <= 1'b1;
      repeat (200) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   // ---------------------------------------------------------------- stimulus
   function automatic wds_pkg::req_type make_beat(logic [1:0] cmd, logic [31:0] value,
                                                  logic [15:0] weight, logic [31:0] fraction);
      wds_pkg::req_type beat;
      beat.cmd           = cmd;
      beat.entry_value   = value;
      beat.entry_weight  = weight;
      beat.rand_fraction = fraction;
      return beat;
   endfunction

   // fields a command ignores carry random content
   task automatic queue_clear();
      outgoing_cmds.push_back(make_beat(wds_pkg::CMD_CLEAR, $urandom, 16'($urandom), $urandom));
   endtask

   task automatic queue_load(logic [31:0] value, logic [15:0] weight);
      outgoing_cmds.push_back(make_beat(wds_pkg::CMD_LOAD, value, weight, $urandom));
   endtask

   task automatic queue_draw(logic [31:0] fraction);
      outgoing_cmds.push_back(make_beat(wds_pkg::CMD_SAMPLE, $urandom, 16'($urandom), fraction));
   endtask

   task automatic queue_unused(logic [31:0] value, logic [15:0] weight, logic [31:0] fraction);
      outgoing_cmds.push_back(make_beat(CMD_UNUSED, value, weight, fraction));
   endtask

   function automatic logic [15:0] pick_weight(weight_mix_type mix);
      case (mix)
         WT_ANY:    return 16'($urandom);
         WT_TINY:   return 16'($urandom_range(0, 3));
         WT_NONE:   return 16'd0;
         WT_SPARSE: return ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'd0;
         default:   return ($urandom_range(0, 1) == 0) ? 16'hFFFF : 16'd0;
      endcase
   endfunction

   // bias toward the two ends of the fraction range
   function automatic logic [31:0] pick_fraction();
      case ($urandom_range(0, 9))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // One well-formed session: usually clear, then loads with draws mixed in,
   // then a run of draws; a little noise from unused commands and early draws.
   task automatic queue_session(int n_loads, weight_mix_type mix);
      int n_draws;
      n_draws = $urandom_range(3, 16);
      if ($urandom_range(0, 99) < 85) queue_clear();
      if ($urandom_range(0, 99) < 10) queue_draw(pick_fraction());
      for (int i = 0; i < n_loads; i++) begin
         if ($urandom_range(0, 99) < 20) queue_draw(pick_fraction());
         if ($urandom_range(0, 99) < 4) queue_unused($urandom, 16'($urandom), $urandom);
         queue_load($urandom, pick_weight(mix));
      end
      repeat (n_draws) queue_draw(pick_fraction());
   endtask

   task automatic queue_sessions(int count);
      int n_loads;
      for (int i = 0; i < count; i++) begin
         n_loads = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
         queue_session(n_loads, weight_mix_type'($urandom_range(0, 4)));
      end
   endtask

   // Fill every entry, push a few loads past the end, then draw from the full table.
   task automatic queue_full_table();
      weight_mix_type mix;
      mix = WT_ANY;
      queue_clear();
      for (int i = 0; i < DEPTH; i++) begin
         if (i % 64 == 0)
            mix = ($urandom_range(0, 3) == 0) ? weight_mix_type'($urandom_range(0, 4)) : WT_ANY;
         if ($urandom_range(0, 99) < 6) queue_draw(pick_fraction());
         queue_load($urandom, pick_weight(mix));
      end
      repeat (4) queue_load($urandom, 16'($urandom));
      queue_unused($urandom, 16'($urandom), $urandom);
      repeat (40) queue_draw(pick_fraction());
   endtask

   // Wait until every pending beat is accepted and every prediction has been met.
   task automatic settle();
      do @(negedge clock);
      while (outgoing_cmds.size() != 0 || req_valid || predicted_draws.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   // Write uniform_mode through a setup and an access cycle, then read it back.
   task automatic program_uniform_mode(bit mode);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= UNIFORM_ADDR;
      csr_pwdata  <= wds_pkg::CSR_DATA_W'(mode);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      uniform_weights = mode;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== wds_pkg::CSR_DATA_W'(mode))
         flag_mismatch("uniform_mode read-back", wds_pkg::CSR_DATA_W'(mode), csr_prdata);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed, weighted: empty table, zero total, then a table of cumulative
      // weights 0, 65535, 65535, 65536 that probes each boundary of the search.
      program_uniform_mode(1'b0);
      @(negedge clock);
      queue_draw(32'h1234_5678);                        // draw on an empty table
      queue_unused($urandom, 16'($urandom), $urandom);  // ignored command
      queue_load(32'hFFFF_FFFF, 16'd0);
      queue_draw(32'hFFFF_FFFF);                        // every weight zero
      queue_load(32'h0000_0000, 16'hFFFF);
      queue_load(32'hA5A5_A5A5, 16'd0);
      queue_load(32'h5A5A_5A5A, 16'd1);
      queue_draw(32'h0000_0000);                        // u = 0 skips the zero-weight head
      queue_draw(32'hFFFE_FFFF);                        // u one below a boundary
      queue_draw(32'hFFFF_0000);                        // u on a boundary moves past it
      queue_draw(32'hFFFF_FFFF);
      queue_draw(32'h8000_0000);
      queue_unused(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
      queue_draw(32'hFFFF_8000);
      queue_clear();
      queue_draw($urandom);                             // cleared table is empty again
      queue_load(32'h0000_00C3, 16'hFFFF);
      queue_draw(32'h0000_0000);
      queue_draw(32'hFFFF_FFFF);
      settle();

      // Directed, uniform: weight fields are ignored and every entry counts one.
      program_uniform_mode(1'b1);
      @(negedge clock);
      queue_clear();
      queue_load(32'h1111_1111, 16'd0);
      queue_load(32'h2222_2222, 16'hFFFF);
      queue_load(32'h3333_3333, 16'h8000);
      queue_draw(32'hAAAA_AAAA);
      queue_draw(32'hFFFF_FFFF);
      settle();

      // Random sessions in uniform mode.
      queue_sessions(2);
      settle();

      // Weighted fill to the last entry and beyond; receiver hold-offs land here.
      program_uniform_mode(1'b0);
      @(negedge clock);
      queue_full_table();
      settle();

      // Uniform mode against the still-full table, then fresh sessions.
      program_uniform_mode(1'b1);
      @(negedge clock);
      queue_load($urandom, 16'($urandom));
      queue_draw(pick_fraction());
      queue_sessions(1);
      settle();

      program_uniform_mode(1'b0);
      @(negedge clock);
      queue_sessions(2);
      settle();
      repeat (40) @(negedge clock);

      $display("Covered %0d beats: %0d clears, %0d loads, %0d loads into a full table, %0d unused",
               n_accepted, n_clear, n_load, n_full, n_unused);
      $display("Draws: %0d picked, %0d on an empty table, %0d on a zero total; deepest table %0d",
               n_draw_ok, n_draw_empty, n_draw_zero, deepest);
      if (n_mismatch == 0 && predicted_draws.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("%0d mismatches, %0d results never arrived", n_mismatch,
                  predicted_draws.size());
         $display("Mismatches found");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #4_000_000;
      $display("Timed out with %0d results outstanding", predicted_draws.size());
      $display("Mismatches found");
      $finish;
   end

endmodule

[files.f]
+incdir+rtl
rtl/wds_pkg.sv
rtl/wds_ram.sv
rtl/weighted_discrete_sampler_unit.sv
tb/testbench.sv
